>>> src/lik_pkg.sv
// ----------------------------------------------------------------------------
// lik_pkg
// Shared types, constants and helpers for the leg inverse kinematics block.
// ----------------------------------------------------------------------------
package lik_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int ANG_ONE_SHIFT   = 16;
  localparam int ANG_W           = 28;
  localparam int NORM_STEPS      = 5;
  localparam int CORDIC_LAT      = NORM_STEPS + CORDIC_STEPS;
  localparam int ISQ_STEPS       = 31;
  localparam int RAD_W           = 2 * ISQ_STEPS;
  localparam int FQ_DEPTH        = 4;
  localparam int OQ_DEPTH        = 2;
  localparam int ATAN_LEN        = 24;

  localparam logic [13:0] UPPER_RESET = 14'd6554;
  localparam logic [13:0] LOWER_RESET = 14'd6042;

  localparam int ANG_SH   = ANG_ONE_SHIFT - ANGLE_FRAC_BITS;
  localparam int ANG_HALF = 1 << (ANG_SH - 1);
  localparam int ANG_UNIT = 1 << ANGLE_FRAC_BITS;
  localparam int YAW_LO   = -90 * ANG_UNIT;
  localparam int YAW_HI   = 90 * ANG_UNIT;
  localparam int PITCH_LO = -90 * ANG_UNIT;
  localparam int PITCH_HI = 180 * ANG_UNIT;
  localparam int KNEE_LO  = -180 * ANG_UNIT;
  localparam int KNEE_HI  = 0;

  localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * 65536);
  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * 65536);

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic [21:0] ATAN_TAB [0:ATAN_LEN-1] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  typedef struct packed {
    logic signed [14:0] x;
    logic signed [14:0] y;
    logic signed [14:0] z;
    logic [29:0]        h2;
    logic signed [31:0] n;
    logic [29:0]        d;
    logic signed [31:0] m;
    logic               reach;
  } lik_item_t;

  typedef struct packed {
    logic neg_n;
    logic yzero;
    logic xpos;
    logic xneg;
    logic xy0;
    logic reach;
  } lik_post_t;

  typedef struct packed {
    logic signed [13:0] hip_yaw;
    logic signed [14:0] hip_pitch;
    logic signed [14:0] knee_angle;
    logic               reachable;
  } lik_result_t;

  // round half up to output units, then clamp
  function automatic logic signed [15:0] sat_angle(input logic signed [ANG_W-1:0] a,
                                                   input int lo, input int hi);
    logic signed [ANG_W-1:0] r;
    r = (a + ANG_W'(ANG_HALF)) >>> ANG_SH;
    if (r < lo) r = ANG_W'(lo);
    if (r > hi) r = ANG_W'(hi);
    return 16'(r);
  endfunction

endpackage

>>> src/lik_isqrt.sv
// ----------------------------------------------------------------------------
// lik_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module lik_isqrt import lik_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [RAD_W-1:0]     rad_in,
  output logic [ISQ_STEPS-1:0] root
);

  logic [RAD_W-1:0]     rad_q  [ISQ_STEPS];
  logic [31:0]          rem_q  [ISQ_STEPS];
  logic [ISQ_STEPS-1:0] root_q [ISQ_STEPS];

  genvar g;
  for (g = 0; g < ISQ_STEPS; g++) begin : g_stage
    logic [RAD_W-1:0]     pr;
    logic [31:0]          prem;
    logic [ISQ_STEPS-1:0] proot;
    logic [33:0]          rem_s;
    logic [33:0]          trial;

    if (g == 0) begin : g_first
      assign pr    = rad_in;
      assign prem  = '0;
      assign proot = '0;
    end else begin : g_rest
      assign pr    = rad_q[g-1];
      assign prem  = rem_q[g-1];
      assign proot = root_q[g-1];
    end

    assign rem_s = {prem, pr[RAD_W-1 -: 2]};
    assign trial = {1'b0, proot, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[g] <= pr << 2;
        if (rem_s >= trial) begin
          rem_q[g]  <= 32'(rem_s - trial);
          root_q[g] <= {proot[ISQ_STEPS-2:0], 1'b1};
        end else begin
          rem_q[g]  <= rem_s[31:0];
          root_q[g] <= {proot[ISQ_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[ISQ_STEPS-1];

endmodule

>>> src/lik_cordic.sv
// ----------------------------------------------------------------------------
// lik_cordic
// Pipelined vectoring CORDIC: normalizes the vector, then one rotation per stage.
// ----------------------------------------------------------------------------
module lik_cordic import lik_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [31:0]      vx_in,
  input  logic signed [31:0]      vy_in,
  output logic signed [ANG_W-1:0] ang
);

  logic [30:0] vy_abs;
  logic [30:0] mag_in;
  logic        zero_in;

  assign vy_abs  = vy_in[31] ? 31'(-vy_in) : vy_in[30:0];
  assign mag_in  = (vx_in[30:0] > vy_abs) ? vx_in[30:0] : vy_abs;
  assign zero_in = (vx_in == '0) && (vy_in == '0);

  logic signed [31:0] nx [NORM_STEPS];
  logic signed [31:0] ny [NORM_STEPS];
  logic [30:0]        nm [NORM_STEPS];
  logic               nz [NORM_STEPS];

  genvar g;
  // shift left by 16, 8, 4, 2, 1 until the top magnitude bit is set
  for (g = 0; g < NORM_STEPS; g++) begin : g_norm
    localparam int SHA = 1 << (NORM_STEPS - 1 - g);
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [30:0]        pm;
    logic               pz;

    if (g == 0) begin : g_first
      assign px = vx_in;
      assign py = vy_in;
      assign pm = mag_in;
      assign pz = zero_in;
    end else begin : g_rest
      assign px = nx[g-1];
      assign py = ny[g-1];
      assign pm = nm[g-1];
      assign pz = nz[g-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (pm[30 -: SHA] == '0) begin
          nx[g] <= px <<< SHA;
          ny[g] <= py <<< SHA;
          nm[g] <= pm << SHA;
        end else begin
          nx[g] <= px;
          ny[g] <= py;
          nm[g] <= pm;
        end
        nz[g] <= pz;
      end
    end
  end

  logic signed [35:0]      cx [CORDIC_STEPS];
  logic signed [35:0]      cy [CORDIC_STEPS];
  logic signed [ANG_W-1:0] ca [CORDIC_STEPS];
  logic                    cz [CORDIC_STEPS];

  for (g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    localparam logic signed [ANG_W-1:0] STEP_ANG = ANG_W'(ATAN_TAB[g]);
    logic signed [35:0]      px;
    logic signed [35:0]      py;
    logic signed [ANG_W-1:0] pa;
    logic                    pz;
    logic signed [35:0]      dx;
    logic signed [35:0]      dy;

    if (g == 0) begin : g_first
      assign px = 36'(nx[NORM_STEPS-1]);
      assign py = 36'(ny[NORM_STEPS-1]);
      assign pa = '0;
      assign pz = nz[NORM_STEPS-1];
    end else begin : g_rest
      assign px = cx[g-1];
      assign py = cy[g-1];
      assign pa = ca[g-1];
      assign pz = cz[g-1];
    end

    assign dx = px >>> g;
    assign dy = py >>> g;

    always_ff @(posedge clk) begin
      if (en) begin
        if (py >= 0) begin
          cx[g] <= px + dy;
          cy[g] <= py - dx;
          ca[g] <= pa + STEP_ANG;
        end else begin
          cx[g] <= px - dy;
          cy[g] <= py + dx;
          ca[g] <= pa - STEP_ANG;
        end
        cz[g] <= pz;
      end
    end
  end

  assign ang = cz[CORDIC_STEPS-1] ? '0 : ca[CORDIC_STEPS-1];

endmodule

>>> src/lik_front.sv
// ----------------------------------------------------------------------------
// lik_front
// Takes targets, forms squares and the law of cosines terms, flags reach,
// and holds classified requests in a short queue for the back end.
// ----------------------------------------------------------------------------
module lik_front import lik_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [14:0] target_x,
  input  logic signed [14:0] target_y,
  input  logic signed [14:0] target_z,
  input  logic [13:0]        upper_len,
  input  logic [13:0]        lower_len,
  output lik_item_t          q_item,
  output logic               q_avail,
  input  logic               q_pop
);

  localparam int FQ_AW = $clog2(FQ_DEPTH);
  localparam int FQ_CW = $clog2(FQ_DEPTH + 1);

  logic accept;
  assign accept = push && !full;

  logic               f1_v;
  logic signed [14:0] fx, fy, fz;
  logic [28:0]        xx, yy, zz;
  logic [27:0]        l1sq, l2sq, l12;
  logic signed [29:0] xsq, ysq, zsq;

  assign xsq = target_x * target_x;
  assign ysq = target_y * target_y;
  assign zsq = target_z * target_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else begin
      f1_v <= accept;
    end
    if (accept) begin
      fx   <= target_x;
      fy   <= target_y;
      fz   <= target_z;
      xx   <= xsq[28:0];
      yy   <= ysq[28:0];
      zz   <= zsq[28:0];
      l1sq <= upper_len * upper_len;
      l2sq <= lower_len * lower_len;
      l12  <= upper_len * lower_len;
    end
  end

  logic [29:0]        h2;
  logic [30:0]        r2;
  logic signed [31:0] n, m, dd;
  lik_item_t          item;

  always_comb begin
    h2 = {1'b0, xx} + {1'b0, yy};
    r2 = {1'b0, h2} + {2'b0, zz};
    n  = $signed({4'b0, l1sq}) + $signed({4'b0, l2sq}) - $signed({1'b0, r2});
    m  = $signed({4'b0, l1sq}) + $signed({1'b0, r2}) - $signed({4'b0, l2sq});
    dd = $signed({3'b0, l12, 1'b0});
    item.x     = fx;
    item.y     = fy;
    item.z     = fz;
    item.h2    = h2;
    item.n     = n;
    item.d     = {1'b0, l12, 1'b0};
    item.m     = m;
    item.reach = (r2 != '0) && (n <= dd) && (n >= -dd);
  end

  lik_item_t        fq_mem [FQ_DEPTH];
  logic [FQ_AW-1:0] wp, rp;
  logic [FQ_CW-1:0] cnt;
  logic             do_pop;

  assign do_pop  = q_pop && (cnt != '0);
  assign q_avail = (cnt != '0);
  assign q_item  = fq_mem[rp];
  // one slot is held back for the request sitting in the square stage
  assign full = ((FQ_CW+1)'(cnt) + (FQ_CW+1)'(f1_v)) >= (FQ_CW+1)'(FQ_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (f1_v) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      cnt <= cnt + FQ_CW'(f1_v) - FQ_CW'(do_pop);
    end
    if (f1_v) fq_mem[wp] <= item;
  end

endmodule

>>> src/lik_back.sv
// ----------------------------------------------------------------------------
// lik_back
// Square roots and four CORDIC angle units in one stall-enabled pipeline,
// then angle assembly, rounding and saturation into a result queue.
// ----------------------------------------------------------------------------
module lik_back import lik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lik_item_t   q_item,
  input  logic        q_avail,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output lik_result_t res
);

  localparam int OQ_AW = $clog2(OQ_DEPTH);
  localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

  logic             en;
  logic             lat_v;
  logic [OQ_CW-1:0] oq_cnt;

  // whole pipe holds only when a finished result has nowhere to go
  assign en    = !lat_v || (oq_cnt != OQ_CW'(OQ_DEPTH)) || pop;
  assign q_pop = en && q_avail;

  // product stage
  logic               b1_v;
  lik_item_t          b1_item;
  logic [RAD_W-1:0]   prod, rad2;
  logic signed [31:0] dm, dp;

  assign dm = $signed({2'b0, q_item.d}) - q_item.n;
  assign dp = $signed({2'b0, q_item.d}) + q_item.n;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (en) begin
      b1_v <= q_avail;
    end
    if (en) begin
      b1_item <= q_item;
      prod    <= {31'b0, dm[30:0]} * {31'b0, dp[30:0]};
      rad2    <= {16'b0, q_item.h2, 16'b0};
    end
  end

  logic [ISQ_STEPS-1:0] s_root, h_root;

  lik_isqrt u_sq_s (.clk(clk), .en(en), .rad_in(prod), .root(s_root));
  lik_isqrt u_sq_h (.clk(clk), .en(en), .rad_in(rad2), .root(h_root));

  lik_item_t sd_item [ISQ_STEPS];
  logic      sd_v    [ISQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ISQ_STEPS; i++) sd_v[i] <= 1'b0;
    end else if (en) begin
      sd_v[0] <= b1_v;
      for (int i = 1; i < ISQ_STEPS; i++) sd_v[i] <= sd_v[i-1];
    end
    if (en) begin
      sd_item[0] <= b1_item;
      for (int i = 1; i < ISQ_STEPS; i++) sd_item[i] <= sd_item[i-1];
    end
  end

  // cordic operand setup
  lik_item_t          it;
  logic               pr_v;
  lik_post_t          pr_post;
  logic signed [31:0] vx0, vy0, vx1, vy1, vx2, vy2, vx3, vy3;

  assign it = sd_item[ISQ_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_v <= 1'b0;
    end else if (en) begin
      pr_v <= sd_v[ISQ_STEPS-1];
    end
    if (en) begin
      vx0 <= it.n[31] ? -it.n : it.n;
      vy0 <= {1'b0, s_root};
      vx1 <= it.m[31] ? -it.m : it.m;
      vy1 <= {1'b0, s_root};
      vx2 <= it.y[14] ? -32'(it.y) : 32'(it.y);
      vy2 <= it.y[14] ? -32'(it.x) : 32'(it.x);
      vx3 <= {1'b0, h_root};
      vy3 <= {{9{it.z[14]}}, it.z, 8'b0};
      pr_post.neg_n <= it.n[31];
      pr_post.yzero <= (it.y == '0);
      pr_post.xpos  <= !it.x[14] && (it.x != '0);
      pr_post.xneg  <= it.x[14];
      pr_post.xy0   <= (it.x == '0) && (it.y == '0);
      pr_post.reach <= it.reach;
    end
  end

  logic signed [ANG_W-1:0] c_eah, c_eha, c_yaw, c_pitch;

  lik_cordic u_eah   (.clk(clk), .en(en), .vx_in(vx0), .vy_in(vy0), .ang(c_eah));
  lik_cordic u_eha   (.clk(clk), .en(en), .vx_in(vx1), .vy_in(vy1), .ang(c_eha));
  lik_cordic u_yaw   (.clk(clk), .en(en), .vx_in(vx2), .vy_in(vy2), .ang(c_yaw));
  lik_cordic u_pitch (.clk(clk), .en(en), .vx_in(vx3), .vy_in(vy3), .ang(c_pitch));

  lik_post_t pp  [CORDIC_LAT];
  logic      ppv [CORDIC_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CORDIC_LAT; i++) ppv[i] <= 1'b0;
    end else if (en) begin
      ppv[0] <= pr_v;
      for (int i = 1; i < CORDIC_LAT; i++) ppv[i] <= ppv[i-1];
    end
    if (en) begin
      pp[0] <= pr_post;
      for (int i = 1; i < CORDIC_LAT; i++) pp[i] <= pp[i-1];
    end
  end

  lik_post_t               lp;
  logic signed [ANG_W-1:0] eah, knee_raw, yaw_raw, pitch_raw;
  logic signed [15:0]      yaw_s, pitch_s, knee_s;
  lik_result_t             fin;

  assign lp    = pp[CORDIC_LAT-1];
  assign lat_v = ppv[CORDIC_LAT-1];

  always_comb begin
    eah      = lp.neg_n ? (ANG_180 - c_eah) : c_eah;
    knee_raw = eah - ANG_180;
    if (lp.yzero) begin
      yaw_raw = lp.xpos ? ANG_90 : (lp.xneg ? -ANG_90 : '0);
    end else begin
      yaw_raw = c_yaw;
    end
    // straight above or below the hip
    pitch_raw = lp.xy0 ? (ANG_90 + c_eha) : (c_pitch + c_eha);
    yaw_s   = sat_angle(yaw_raw, YAW_LO, YAW_HI);
    pitch_s = sat_angle(pitch_raw, PITCH_LO, PITCH_HI);
    knee_s  = sat_angle(knee_raw, KNEE_LO, KNEE_HI);
    fin.hip_yaw    = lp.reach ? yaw_s[13:0] : '0;
    fin.hip_pitch  = lp.reach ? pitch_s[14:0] : '0;
    fin.knee_angle = lp.reach ? knee_s[14:0] : '0;
    fin.reachable  = lp.reach;
  end

  // result queue
  lik_result_t      oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] owp, orp;
  logic             do_push, do_pop;

  assign do_push = en && lat_v;
  assign do_pop  = pop && (oq_cnt != '0);
  assign empty   = (oq_cnt == '0);
  assign res     = oq_mem[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      owp    <= '0;
      orp    <= '0;
      oq_cnt <= '0;
    end else begin
      if (do_push) owp <= owp + 1'b1;
      if (do_pop) orp <= orp + 1'b1;
      oq_cnt <= oq_cnt + OQ_CW'(do_push) - OQ_CW'(do_pop);
    end
    if (do_push) oq_mem[owp] <= fin;
  end

endmodule

>>> src/leg_inverse_kinematics_3dof.sv
// ----------------------------------------------------------------------------
// leg_inverse_kinematics_3dof
// Three-joint leg inverse kinematics: foot target in, hip yaw, hip pitch,
// knee angle and reach flag out.
// ----------------------------------------------------------------------------
// throughput: one request per cycle unless a full result queue stalls the pipe, set by the fully pipelined square root
//   (31 stages) and CORDIC units (5 normalize + 16 rotation stages)
// reset: synchronous; queues emptied, link lengths back to 6554 and 6042
module leg_inverse_kinematics_3dof import lik_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [14:0] target_x,
  input  logic signed [14:0] target_y,
  input  logic signed [14:0] target_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [13:0] hip_yaw,
  output logic signed [14:0] hip_pitch,
  output logic signed [14:0] knee_angle,
  output logic               reachable,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic REG_UPPER = 1'b0;
  localparam logic REG_LOWER = 1'b1;

  logic [13:0] upper_link_length, lower_link_length;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link_length <= UPPER_RESET;
      lower_link_length <= LOWER_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_UPPER: upper_link_length <= pwdata[13:0];
        REG_LOWER: lower_link_length <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_UPPER: prdata = {18'b0, upper_link_length};
      REG_LOWER: prdata = {18'b0, lower_link_length};
      default:   prdata = '0;
    endcase
  end

  lik_item_t   q_item;
  logic        q_avail, q_pop;
  lik_result_t res;

  lik_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .target_x  (target_x),
    .target_y  (target_y),
    .target_z  (target_z),
    .upper_len (upper_link_length),
    .lower_len (lower_link_length),
    .q_item    (q_item),
    .q_avail   (q_avail),
    .q_pop     (q_pop)
  );

  lik_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_avail (q_avail),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign hip_yaw    = res.hip_yaw;
  assign hip_pitch  = res.hip_pitch;
  assign knee_angle = res.knee_angle;
  assign reachable  = res.reachable;

`ifndef ASSERT_OFF
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !reachable) |-> (hip_yaw == '0 && hip_pitch == '0 && knee_angle == '0))
    else $error("unreachable result carries nonzero angles");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && reachable) |-> (hip_yaw >= -14'sd5760 && hip_yaw <= 14'sd5760))
    else $error("hip yaw out of range");

  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (empty && !full))
    else $error("queues not empty after reset");
`endif

endmodule

>>> dv/leg_inverse_kinematics_3dof_test.sv
// ----------------------------------------------------------------------------
// leg_inverse_kinematics_3dof_test
// Self-checking bench for the leg inverse kinematics block: drives foot
// targets through the request queue, predicts the joint angles in the bench
// and compares every result, across several link length settings.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics_3dof_test;
  import lik_pkg::*;

  localparam int SETTLE_CYCLES = 70;
  localparam int STALL_LIMIT   = 3000;
  localparam logic [2:0] UPPER_ADDR = 3'd0;
  localparam logic [2:0] LOWER_ADDR = 3'd4;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic signed [14:0] target_x = '0;
  logic signed [14:0] target_y = '0;
  logic signed [14:0] target_z = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [13:0] hip_yaw;
  logic signed [14:0] hip_pitch;
  logic signed [14:0] knee_angle;
  logic               reachable;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  leg_inverse_kinematics_3dof dut (.*);

  always #5 clk = ~clk;

  logic [13:0] upper_len = UPPER_RESET;
  logic [13:0] lower_len = LOWER_RESET;
  lik_result_t pose_expect_q[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          pop_wait = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // atan2(vy, vx) for vx >= 0, degrees with 16 fraction bits
  function automatic longint cordic_angle(input longint vx, input longint vy);
    longint ang;
    longint mag;
    longint dx;
    longint dy;
    ang = 0;
    if (vx == 0 && vy == 0) return 0;
    mag = (vy < 0) ? -vy : vy;
    if (vx > mag) mag = vx;
    while (mag >= (longint'(1) << 31)) begin
      vx = vx >>> 1;
      vy = vy >>> 1;
      mag = mag >>> 1;
    end
    while (mag < (longint'(1) << 30)) begin
      vx = vx * 2;
      vy = vy * 2;
      mag = mag * 2;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
      dx = vx >>> i;
      dy = vy >>> i;
      if (vy >= 0) begin
        vx = vx + dy;
        vy = vy - dx;
        ang = ang + longint'(ATAN_TAB[i]);
      end else begin
        vx = vx - dy;
        vy = vy + dx;
        ang = ang - longint'(ATAN_TAB[i]);
      end
    end
    return ang;
  endfunction

  function automatic longint quantize(input longint a, input longint lo_deg,
                                      input longint hi_deg);
    int     sh;
    longint v;
    sh = ANG_ONE_SHIFT - ANGLE_FRAC_BITS;
    v = (a + (longint'(1) << (sh - 1))) >>> sh;
    if (v < lo_deg * (1 << ANGLE_FRAC_BITS)) v = lo_deg * (1 << ANGLE_FRAC_BITS);
    if (v > hi_deg * (1 << ANGLE_FRAC_BITS)) v = hi_deg * (1 << ANGLE_FRAC_BITS);
    return v;
  endfunction

  function automatic lik_result_t solve_leg(input logic signed [14:0] tx,
                                            input logic signed [14:0] ty,
                                            input logic signed [14:0] tz);
    lik_result_t r;
    longint x, y, z, l1, l2, h2, r2, n, d, m, s, eah, eha, yaw, pitch, hs;
    x = tx;
    y = ty;
    z = tz;
    l1 = upper_len;
    l2 = lower_len;
    h2 = x * x + y * y;
    r2 = h2 + z * z;
    n = l1 * l1 + l2 * l2 - r2;
    d = 2 * l1 * l2;
    r = '0;
    if (r2 == 0 || n > d || n < -d) return r;
    s = longint'(int_sqrt(64'(d - n) * 64'(d + n)));
    if (n >= 0) eah = cordic_angle(n, s);
    else eah = 180 * 65536 - cordic_angle(-n, s);
    m = l1 * l1 + r2 - l2 * l2;
    eha = cordic_angle(m < 0 ? -m : m, s);
    if (y == 0) yaw = (x > 0) ? 90 * 65536 : ((x < 0) ? -90 * 65536 : 0);
    else yaw = cordic_angle(y < 0 ? -y : y, y < 0 ? -x : x);
    if (x == 0 && y == 0) begin
      pitch = 90 * 65536 + eha;
    end else begin
      hs = longint'(int_sqrt(64'(h2) << 16));
      pitch = cordic_angle(hs, z * 256) + eha;
    end
    r.hip_yaw    = 14'(quantize(yaw, -90, 90));
    r.hip_pitch  = 15'(quantize(pitch, -90, 180));
    r.knee_angle = 15'(quantize(eah - 180 * 65536, -180, 0));
    r.reachable  = 1'b1;
    return r;
  endfunction

  function automatic int draw_wait();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // result side: stall between pops, then check the head against the oldest expectation
  always @(posedge clk) begin
    lik_result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (pose_expect_q.size() == 0) begin
          report("unexpected result", hip_yaw, 0);
        end else begin
          want = pose_expect_q.pop_front();
          if (hip_yaw !== want.hip_yaw) report("hip_yaw", hip_yaw, want.hip_yaw);
          if (hip_pitch !== want.hip_pitch) report("hip_pitch", hip_pitch, want.hip_pitch);
          if (knee_angle !== want.knee_angle)
            report("knee_angle", knee_angle, want.knee_angle);
          if (reachable !== want.reachable)
            report("reachable", reachable, want.reachable);
        end
        pop_wait = draw_wait();
        pop <= (pop_wait == 0);
      end else if (!pop) begin
        if (pop_wait > 0) pop_wait--;
        pop <= (pop_wait == 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_target(input logic signed [14:0] tx, input logic signed [14:0] ty,
                             input logic signed [14:0] tz);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    target_x <= tx;
    target_y <= ty;
    target_z <= tz;
    @(posedge clk);
    while (full) @(posedge clk);
    pose_expect_q.push_back(solve_leg(tx, ty, tz));
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pose_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == UPPER_ADDR) upper_len = value[13:0];
    else if (addr == LOWER_ADDR) lower_len = value[13:0];
  endtask

  task automatic set_links(input logic [31:0] l1, input logic [31:0] l2);
    drain();
    write_reg(UPPER_ADDR, l1);
    write_reg(LOWER_ADDR, l2);
  endtask

  task automatic test_directed_poses();
    send_target(0, 0, 0);              // origin
    send_target(0, 0, 8000);           // straight up
    send_target(0, 0, -8000);          // straight down
    send_target(9000, 0, 2000);        // zero y, positive x
    send_target(-9000, 0, -2000);      // zero y, negative x
    send_target(0, 7000, 3000);
    send_target(5000, -6000, 1000);
    send_target(-5000, -6000, -1000);
    send_target(-16384, -16384, -16384);
    send_target(16383, 16383, 16383);
    send_target(0, 0, 12596);          // fully stretched
    send_target(0, 0, 512);            // folded close to the hip
    send_target(1, 1, 1);
    send_target(-1, 16383, 0);
  endtask

  task automatic test_link_extremes();
    set_links(16383, 16383);
    send_target(16383, 16383, 16383);
    send_target(-16384, 0, 0);
    send_target(0, 0, -16384);
    send_target(3, -2, 1);
    set_links(1, 1);
    send_target(1, 0, 0);
    send_target(0, 1, 1);
    send_target(0, 0, 2);
    send_target(1, 1, 0);
    set_links(0, 6042);                // zero length upper link
    send_target(0, 6042, 0);
    send_target(0, 0, -6042);
    send_target(100, 200, 300);
  endtask

  task automatic test_random_poses(input int count);
    int   reach;
    int   span;
    logic signed [14:0] tx, ty, tz;
    reach = upper_len + lower_len;
    span = (reach * 60) / 100;
    if (span > 16383) span = 16383;
    if (span < 1) span = 1;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0: begin
          tx = 15'($urandom);
          ty = 15'($urandom);
          tz = 15'($urandom);
        end
        1: begin
          tx = 0;
          ty = 0;
          tz = 15'($urandom_range(0, 2 * span) - span);
        end
        2: begin
          tx = 15'($urandom_range(0, 2 * span) - span);
          ty = 0;
          tz = 15'($urandom_range(0, 2 * span) - span);
        end
        default: begin
          tx = 15'($urandom_range(0, 2 * span) - span);
          ty = 15'($urandom_range(0, 2 * span) - span);
          tz = 15'($urandom_range(0, 2 * span) - span);
        end
      endcase
      send_target(tx, ty, tz);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_poses();
    test_link_extremes();
    set_links(UPPER_RESET, LOWER_RESET);
    test_random_poses(250);
    set_links(16383, 16383);
    test_random_poses(150);
    set_links(1, 1);
    test_random_poses(100);
    set_links($urandom_range(1, 16383), $urandom_range(1, 16383));
    test_random_poses(200);
    set_links(12000, 2500);
    test_random_poses(200);
    drain();
    if (error_count == 0 && pose_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
